@@ rtl/spectral_reassignment_accumulator_assert.svh @@
// Assertion macros for the spectral reassignment accumulator.
// Used by the top level only; no other dependencies.
`ifndef SPECTRAL_REASSIGNMENT_ACCUMULATOR_ASSERT_SVH
`define SPECTRAL_REASSIGNMENT_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SRA_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("sra assertion failed");
`define SRA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sra assertion failed");
`else
`define SRA_ASSERT(lbl, expr)
`define SRA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/sra_pkg.sv @@
// Shared constants, types and codes of the spectral reassignment accumulator.
// No dependencies.
`timescale 1ns / 1ps
package sra_pkg;
   localparam int FBIN_BITS      = 10;
   localparam int MAX_FREQ_BINS  = 1 << FBIN_BITS;
   localparam int MAX_INPUT_BINS = 1024;
   localparam int FRAME_BITS     = 4;
   localparam int FRAME_RING     = 1 << FRAME_BITS;
   localparam int ACC_WIDTH      = 40;
   localparam int ACC_ADDR_BITS  = FRAME_BITS + FBIN_BITS;
   localparam int ACC_DEPTH      = FRAME_RING * MAX_FREQ_BINS;
   localparam int GRID_WIDTH     = 31;
   localparam int DIV_W          = 40;
   localparam int DSR_W          = 28;
   localparam int DIV_CNT_W      = $clog2(DIV_W);
   localparam int X_W            = 42;
   localparam int PROD_W         = 54;

   typedef enum logic [1:0] {
      REQ_REASSIGN = 2'd0,
      REQ_LOAD     = 2'd1,
      REQ_READ     = 2'd2,
      REQ_NONE     = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_FREQ_OUT  = 3'd1,
      ST_LOW_POWER = 3'd2,
      ST_FREQ_LOCK = 3'd3,
      ST_TIME_LOCK = 3'd4,
      ST_GRID      = 3'd5,
      ST_READ      = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      REG_NUM_BINS    = 3'd0,
      REG_FREQ_BINS   = 3'd1,
      REG_FRAME_SHIFT = 3'd2,
      REG_Q_THRESHOLD = 3'd3,
      REG_FREQ_LOCK   = 3'd4,
      REG_LOCK_BEFORE = 3'd5,
      REG_LOCK_AFTER  = 3'd6,
      REG_GRID_MODE   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [10:0] num_bins;
      logic [10:0] freq_bins;
      logic [15:0] frame_shift;
      logic [31:0] q_threshold;
      logic [30:0] freq_lock;
      logic [2:0]  lock_before;
      logic [2:0]  lock_after;
      logic        grid_mode;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage

@@ rtl/spectral_reassignment_accumulator.sv @@
// Spectral reassignment accumulator: input and result channels with valid/ready,
// APB-style configuration port. The reassign path is sequenced around one shared
// restoring divider (fref, then frame offset); accumulator and grid table are RAMs.
//
// Items enter on req_* and each produces one result on rsp_* (req_type 3 makes none).
// The block takes one item at a time; req_ready is high only while it is idle.
// Paths, accept to result valid:
//   load grid entry      grid write at accept
//   read and clear       accumulator read, then a write of zero
//   reassign, uniform    two divider runs plus mapping
//   reassign, table      as uniform, plus a binary search of the grid
//                        table, one step at a time through its single read port
// The divider sets the rate: each run takes one cycle per quotient bit.
// After reset the accumulator is cleared one cell a cycle, every cell in turn, during which
// req_ready stays low; configuration writes are taken at any time. Grid entries are
// undefined until loaded. A result sits in an output register until rsp_ready takes
// it; the next item is accepted meanwhile, and its result waits until the register
// frees up.
// Depends on sra_pkg, sra_ram, sra_div, sra_csr and the assertion header.
`timescale 1ns / 1ps
`include "spectral_reassignment_accumulator_assert.svh"
module spectral_reassignment_accumulator import sra_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [3:0]           req_frame,
   input  logic [9:0]           req_bin_index,
   input  logic [31:0]          req_power,
   input  logic signed [31:0]   req_time_disp,
   input  logic signed [31:0]   req_freq_disp,
   input  logic [30:0]          req_grid_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [3:0]           rsp_target_frame,
   output logic [9:0]           rsp_target_bin,
   output logic [39:0]          rsp_cell_value,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   typedef enum logic [16:0] {
      S_CLEAR = 17'h00001,
      S_IDLE  = 17'h00002,
      S_FDIV  = 17'h00004,
      S_UMUL  = 17'h00008,
      S_URND  = 17'h00010,
      S_TLO   = 17'h00020,
      S_THI   = 17'h00040,
      S_TCHK  = 17'h00080,
      S_TBS   = 17'h00100,
      S_TBW   = 17'h00200,
      S_TFA   = 17'h00400,
      S_TFB   = 17'h00800,
      S_TDIV  = 17'h01000,
      S_CHECK = 17'h02000,
      S_ACCRD = 17'h04000,
      S_ACCWR = 17'h08000,
      S_RESP  = 17'h10000
   } state_type;

   cfg_type      cfg;
   div_stat_type div_stat;
   logic [DIV_W-1:0] div_quot, div_dvd;
   logic [DSR_W-1:0] div_dsr;
   logic             div_start;

   state_type state_ff, state_in;
   logic [ACC_ADDR_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic [FRAME_BITS-1:0]    frame_ff, frame_in;
   logic [31:0]              power_ff, power_in;
   logic signed [31:0]       td_ff, td_in, fd_ff, fd_in;
   logic                     op_read_ff, op_read_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [FBIN_BITS-1:0]     lo_ff, lo_in, hi_ff, hi_in, fhat_ff, fhat_in;
   logic [GRID_WIDTH-1:0]    glo_ff, glo_in;
   logic [ACC_ADDR_BITS-1:0] idx_ff, idx_in;
   logic [2:0]               res_status_ff, res_status_in;
   logic [3:0]               res_frame_ff, res_frame_in;
   logic [9:0]               res_bin_ff, res_bin_in;
   logic [ACC_WIDTH-1:0]     res_value_ff, res_value_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               rsp_status_ff, rsp_status_in;
   logic [3:0]               rsp_frame_ff, rsp_frame_in;
   logic [9:0]               rsp_bin_ff, rsp_bin_in;
   logic [ACC_WIDTH-1:0]     rsp_value_ff, rsp_value_in;

   logic [10:0]              n_eff, nf_eff;
   logic [15:0]              ds_eff;
   logic [31:0]              abs_td, abs_fd;
   logic                     accept;
   logic                     grid_we, acc_we;
   logic [FBIN_BITS-1:0]     grid_addr, mid;
   logic [GRID_WIDTH-1:0]    grid_rdata;
   logic [ACC_ADDR_BITS-1:0] acc_addr;
   logic [ACC_WIDTH-1:0]     acc_wdata, acc_rdata, acc_sat;
   logic [ACC_WIDTH:0]       acc_sum;
   logic signed [X_W-1:0]    g_ext, glo_ext, dlo, dhi;
   logic [PROD_W-1:0]        prod_mag;
   logic [23:0]              uq;
   logic                     u_ok;
   logic [DIV_W-1:0]         tq;
   logic                     t_fail, f_fail, p_fail;
   logic [FRAME_BITS-1:0]    t_off;

   sra_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   sra_ram #(.WIDTH(GRID_WIDTH), .DEPTH(MAX_FREQ_BINS)) u_grid (
      .clock (clock),
      .we    (grid_we),
      .addr  (grid_addr),
      .wdata (req_grid_value),
      .rdata (grid_rdata)
   );

   sra_ram #(.WIDTH(ACC_WIDTH), .DEPTH(ACC_DEPTH)) u_acc (
      .clock (clock),
      .we    (acc_we),
      .addr  (acc_addr),
      .wdata (acc_wdata),
      .rdata (acc_rdata)
   );

   // effective register values
   always_comb begin
      if (cfg.num_bins == 11'd0) begin
         n_eff = 11'd1;
      end else if (cfg.num_bins > 11'(MAX_INPUT_BINS)) begin
         n_eff = 11'(MAX_INPUT_BINS);
      end else begin
         n_eff = cfg.num_bins;
      end
      nf_eff = (cfg.freq_bins > 11'(MAX_FREQ_BINS)) ? 11'(MAX_FREQ_BINS) : cfg.freq_bins;
      ds_eff = (cfg.frame_shift == 16'd0) ? 16'd1 : cfg.frame_shift;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign abs_td    = td_ff[31] ? 32'(-td_ff) : 32'(td_ff);
   assign abs_fd    = fd_ff[31] ? 32'(-fd_ff) : 32'(fd_ff);
   assign mid       = FBIN_BITS'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

   // divider operands: fref at accept, frame offset otherwise
   always_comb begin
      if (state_ff == S_IDLE) begin
         div_dvd = {req_bin_index, 30'd0};
         div_dsr = DSR_W'(n_eff);
      end else begin
         div_dvd = DIV_W'(abs_td) + DIV_W'({ds_eff, 11'd0});
         div_dsr = {ds_eff, 12'd0};
      end
   end

   always_comb begin
      case (state_ff)
         S_TLO:   grid_addr = '0;
         S_THI:   grid_addr = FBIN_BITS'(nf_eff - 11'd1);
         S_TBS:   grid_addr = (lo_ff == hi_ff) ? lo_ff - 1'b1 : mid;
         S_TFA:   grid_addr = lo_ff;
         default: grid_addr = req_bin_index;
      endcase
   end
   assign grid_we = accept && (req_kind_type'(req_type) == REQ_LOAD);

   assign acc_addr  = (state_ff == S_CLEAR) ? clr_cnt_ff : idx_ff;
   assign acc_we    = (state_ff == S_CLEAR) || (state_ff == S_ACCWR);
   assign acc_sum   = {1'b0, acc_rdata} + (ACC_WIDTH + 1)'(power_ff);
   assign acc_sat   = acc_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];
   assign acc_wdata = (state_ff == S_ACCWR && !op_read_ff) ? acc_sat : '0;

   assign g_ext   = $signed({{(X_W - GRID_WIDTH){1'b0}}, grid_rdata});
   assign glo_ext = $signed({{(X_W - GRID_WIDTH){1'b0}}, glo_ff});
   assign dlo     = x_ff - glo_ext;
   assign dhi     = g_ext - x_ff;

   // uniform grid rounding, half away from zero
   assign prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign uq       = 24'((prod_mag + PROD_W'(1 << 29)) >> 30);
   assign u_ok     = prod_ff[PROD_W-1] ? (uq == 24'd0) : (uq < 24'(nf_eff));

   assign tq     = div_quot;
   assign t_off  = td_ff[31] ? FRAME_BITS'(-tq[FRAME_BITS-1:0]) : tq[FRAME_BITS-1:0];
   assign p_fail = power_ff <= cfg.q_threshold;
   assign f_fail = (cfg.freq_lock != '0) && (abs_fd > {1'b0, cfg.freq_lock});
   assign t_fail = td_ff[31] ? (tq > DIV_W'(cfg.lock_before)) : (tq > DIV_W'(cfg.lock_after));

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      frame_in      = frame_ff;
      power_in      = power_ff;
      td_in         = td_ff;
      fd_in         = fd_ff;
      op_read_in    = op_read_ff;
      x_in          = x_ff;
      prod_in       = prod_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      fhat_in       = fhat_ff;
      glo_in        = glo_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_bin_in    = res_bin_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_bin_in    = rsp_bin_ff;
      rsp_value_in  = rsp_value_ff;
      div_start     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               frame_in   = req_frame[FRAME_BITS-1:0];
               power_in   = req_power;
               td_in      = req_time_disp;
               fd_in      = req_freq_disp;
               op_read_in = 1'b0;
               case (req_kind_type'(req_type))
                  REQ_REASSIGN: begin
                     div_start = 1'b1;
                     state_in  = S_FDIV;
                  end
                  REQ_LOAD: begin
                     res_status_in = ST_GRID;
                     res_frame_in  = '0;
                     res_bin_in    = req_bin_index;
                     res_value_in  = ACC_WIDTH'(req_grid_value);
                     state_in      = S_RESP;
                  end
                  REQ_READ: begin
                     op_read_in = 1'b1;
                     idx_in     = {req_frame[FRAME_BITS-1:0], req_bin_index};
                     state_in   = S_ACCRD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FDIV: begin
            if (div_stat.done) begin
               x_in     = $signed({2'b00, div_quot}) - X_W'(fd_ff);
               state_in = cfg.grid_mode ? S_TLO : S_UMUL;
            end
         end
         S_UMUL: begin
            prod_in  = x_ff * $signed({1'b0, nf_eff});
            state_in = S_URND;
         end
         S_URND: begin
            if (u_ok) begin
               fhat_in   = uq[FBIN_BITS-1:0];
               div_start = 1'b1;
               state_in  = S_TDIV;
            end else begin
               res_status_in = ST_FREQ_OUT;
               res_frame_in  = '0;
               res_bin_in    = '0;
               res_value_in  = '0;
               state_in      = S_RESP;
            end
         end
         S_TLO: state_in = S_THI;
         S_THI: begin
            glo_in   = grid_rdata;
            state_in = S_TCHK;
         end
         S_TCHK: begin
            if (nf_eff == 11'd0 || x_ff < glo_ext || x_ff > g_ext) begin
               res_status_in = ST_FREQ_OUT;
               res_frame_in  = '0;
               res_bin_in    = '0;
               res_value_in  = '0;
               state_in      = S_RESP;
            end else if (nf_eff == 11'd1) begin
               fhat_in   = '0;
               div_start = 1'b1;
               state_in  = S_TDIV;
            end else begin
               lo_in    = FBIN_BITS'(1);
               hi_in    = FBIN_BITS'(nf_eff - 11'd1);
               state_in = S_TBS;
            end
         end
         // lower bound of x in entries lo..hi
         S_TBS: state_in = (lo_ff == hi_ff) ? S_TFA : S_TBW;
         S_TBW: begin
            if (g_ext >= x_ff) begin
               hi_in = mid;
            end else begin
               lo_in = mid + 1'b1;
            end
            state_in = S_TBS;
         end
         S_TFA: begin
            glo_in   = grid_rdata;
            state_in = S_TFB;
         end
         S_TFB: begin
            // tie goes to the upper entry
            fhat_in   = (dlo < dhi) ? lo_ff - 1'b1 : lo_ff;
            div_start = 1'b1;
            state_in  = S_TDIV;
         end
         S_TDIV: begin
            if (div_stat.done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_frame_in = '0;
            res_bin_in   = '0;
            res_value_in = '0;
            state_in     = S_RESP;
            if (p_fail) begin
               res_status_in = ST_LOW_POWER;
            end else if (f_fail) begin
               res_status_in = ST_FREQ_LOCK;
            end else if (t_fail) begin
               res_status_in = ST_TIME_LOCK;
            end else begin
               idx_in   = {frame_ff + t_off, fhat_ff};
               state_in = S_ACCRD;
            end
         end
         S_ACCRD: state_in = S_ACCWR;
         S_ACCWR: begin
            res_status_in = op_read_ff ? ST_READ : ST_ADDED;
            res_frame_in  = 4'(idx_ff[ACC_ADDR_BITS-1:FBIN_BITS]);
            res_bin_in    = 10'(idx_ff[FBIN_BITS-1:0]);
            res_value_in  = op_read_ff ? acc_rdata : acc_sat;
            state_in      = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_frame_in  = res_frame_ff;
               rsp_bin_in    = res_bin_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff      <= frame_in;
      power_ff      <= power_in;
      td_ff         <= td_in;
      fd_ff         <= fd_in;
      op_read_ff    <= op_read_in;
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      fhat_ff       <= fhat_in;
      glo_ff        <= glo_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_bin_ff    <= res_bin_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_target_frame = rsp_frame_ff;
   assign rsp_target_bin   = rsp_bin_ff;
   assign rsp_cell_value   = rsp_value_ff;

   `SRA_ASSERT(a_div_start_idle, !(div_start && div_stat.busy))
   `SRA_ASSERT_NEXT(a_one_item, accept && req_type != REQ_NONE, !req_ready)
   `SRA_ASSERT(a_read_status, !(state_ff == S_RESP && op_read_ff && res_status_ff != ST_READ))
endmodule

@@ rtl/sra_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/sra_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on sra_pkg.
`timescale 1ns / 1ps
module sra_div import sra_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output div_stat_type     stat
);
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DSR_W:0]       rem_sh;
   logic [DSR_W:0]       diff;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_W-1]};
      diff    = rem_sh - {1'b0, dsr_ff};
      ge      = rem_sh >= {1'b0, dsr_ff};
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign quotient  = dvd_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule

@@ rtl/sra_csr.sv @@
// Configuration register file behind an APB-style port.
// Depends on sra_pkg.
`timescale 1ns / 1ps
module sra_csr import sra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);
   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(csr_paddr[4:2]);
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_NUM_BINS:    cfg_in.num_bins    = csr_pwdata[10:0];
            REG_FREQ_BINS:   cfg_in.freq_bins   = csr_pwdata[10:0];
            REG_FRAME_SHIFT: cfg_in.frame_shift = csr_pwdata[15:0];
            REG_Q_THRESHOLD: cfg_in.q_threshold = csr_pwdata;
            REG_FREQ_LOCK:   cfg_in.freq_lock   = csr_pwdata[30:0];
            REG_LOCK_BEFORE: cfg_in.lock_before = csr_pwdata[2:0];
            REG_LOCK_AFTER:  cfg_in.lock_after  = csr_pwdata[2:0];
            REG_GRID_MODE:   cfg_in.grid_mode   = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_NUM_BINS:    csr_prdata = {21'd0, cfg_ff.num_bins};
         REG_FREQ_BINS:   csr_prdata = {21'd0, cfg_ff.freq_bins};
         REG_FRAME_SHIFT: csr_prdata = {16'd0, cfg_ff.frame_shift};
         REG_Q_THRESHOLD: csr_prdata = cfg_ff.q_threshold;
         REG_FREQ_LOCK:   csr_prdata = {1'b0, cfg_ff.freq_lock};
         REG_LOCK_BEFORE: csr_prdata = {29'd0, cfg_ff.lock_before};
         REG_LOCK_AFTER:  csr_prdata = {29'd0, cfg_ff.lock_after};
         REG_GRID_MODE:   csr_prdata = {31'd0, cfg_ff.grid_mode};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_bins    <= 11'd257;
         cfg_ff.freq_bins   <= 11'd257;
         cfg_ff.frame_shift <= 16'd10;
         cfg_ff.q_threshold <= '0;
         cfg_ff.freq_lock   <= '0;
         cfg_ff.lock_before <= '0;
         cfg_ff.lock_after  <= '0;
         cfg_ff.grid_mode   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;
endmodule

@@ dv/sra_checker.sv @@
// Checker for the spectral reassignment accumulator: snoops the register port and both
// item channels, predicts every result and compares it field by field.
// Depends on sra_pkg.
`timescale 1ns / 1ps
module sra_checker import sra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [3:0]         req_frame,
   input  logic [9:0]         req_bin_index,
   input  logic [31:0]        req_power,
   input  logic signed [31:0] req_time_disp,
   input  logic signed [31:0] req_freq_disp,
   input  logic [30:0]        req_grid_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_status,
   input  logic [3:0]         rsp_target_frame,
   input  logic [9:0]         rsp_target_bin,
   input  logic [39:0]        rsp_cell_value,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 mismatches,
   output int                 outstanding,
   output int                 results_seen
);
   typedef struct {
      status_type  status;
      logic [3:0]  frame;
      logic [9:0]  bin;
      logic [39:0] value;
   } cell_outcome_type;

   localparam logic [39:0] CELL_MAX = {ACC_WIDTH{1'b1}};

   cell_outcome_type awaited_cells[$];
   logic [39:0]      cell_sum [ACC_DEPTH];
   logic [30:0]      grid_freq [MAX_FREQ_BINS];
   cfg_type          shadow;

   assign outstanding = awaited_cells.size();

   // half away from zero; den > 0
   function automatic longint round_half_out(longint num, longint den);
      if (num >= 0) return (2 * num + den) / (2 * den);
      return -((-2 * num + den) / (2 * den));
   endfunction

   // nearest grid entry, ties to the upper one; -1 when outside the table
   function automatic longint nearest_grid_bin(longint x, longint n);
      longint gap;
      if (n < 1) return -1;
      if (x < longint'(grid_freq[0]) || x > longint'(grid_freq[n - 1])) return -1;
      if (n == 1) return 0;
      for (longint i = 1; i < n; i++) begin
         gap = longint'(grid_freq[i]) - x;
         if (gap >= 0) return ((x - longint'(grid_freq[i - 1])) < gap) ? i - 1 : i;
      end
      return -1;
   endfunction

   function automatic cell_outcome_type reassign_bin();
      cell_outcome_type r;
      longint n, nf, ds, td, fd, fref, x, fhat, shift, afd, tf;
      logic [39:0] sum;
      int idx;
      r = '{ST_ADDED, 4'd0, 10'd0, 40'd0};
      n  = (shadow.num_bins == 0) ? 1 : longint'(shadow.num_bins);
      if (n > MAX_INPUT_BINS) n = MAX_INPUT_BINS;
      nf = longint'(shadow.freq_bins);
      if (nf > MAX_FREQ_BINS) nf = MAX_FREQ_BINS;
      ds = (shadow.frame_shift == 0) ? 1 : longint'(shadow.frame_shift);
      td = longint'(req_time_disp);
      fd = longint'(req_freq_disp);
      fref = (longint'(req_bin_index) << 30) / n;
      x = fref - fd;
      if (!shadow.grid_mode) begin
         fhat = round_half_out(x * nf, longint'(1) << 30);
         if (fhat < 0 || fhat >= nf) fhat = -1;
      end else begin
         fhat = nearest_grid_bin(x, nf);
      end
      if (fhat < 0) begin
         r.status = ST_FREQ_OUT;
         return r;
      end
      shift = round_half_out(td, ds * 4096);
      afd = (fd < 0) ? -fd : fd;
      if (longint'(req_power) <= longint'(shadow.q_threshold)) r.status = ST_LOW_POWER;
      else if (shadow.freq_lock != 0 && afd > longint'(shadow.freq_lock))
         r.status = ST_FREQ_LOCK;
      else if (shift > longint'(shadow.lock_after) || shift < -longint'(shadow.lock_before))
         r.status = ST_TIME_LOCK;
      if (r.status != ST_ADDED) return r;
      tf = (longint'(req_frame) + shift + 8 * FRAME_RING) % FRAME_RING;
      idx = int'(tf) * MAX_FREQ_BINS + int'(fhat);
      sum = cell_sum[idx];
      sum = (CELL_MAX - sum < {8'd0, req_power}) ? CELL_MAX : sum + req_power;
      cell_sum[idx] = sum;
      r.frame = tf[3:0];
      r.bin   = fhat[9:0];
      r.value = sum;
      return r;
   endfunction

   always @(posedge clock) begin
      cell_outcome_type want;
      int idx;
      if (reset) begin
         awaited_cells.delete();
         foreach (cell_sum[i]) cell_sum[i] = '0;
         foreach (grid_freq[i]) grid_freq[i] = '0;
         shadow = '{num_bins: 11'd257, freq_bins: 11'd257, frame_shift: 16'd10,
                    default: '0};
         mismatches   = 0;
         results_seen = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_NUM_BINS:    shadow.num_bins    = csr_pwdata[10:0];
               REG_FREQ_BINS:   shadow.freq_bins   = csr_pwdata[10:0];
               REG_FRAME_SHIFT: shadow.frame_shift = csr_pwdata[15:0];
               REG_Q_THRESHOLD: shadow.q_threshold = csr_pwdata;
               REG_FREQ_LOCK:   shadow.freq_lock   = csr_pwdata[30:0];
               REG_LOCK_BEFORE: shadow.lock_before = csr_pwdata[2:0];
               REG_LOCK_AFTER:  shadow.lock_after  = csr_pwdata[2:0];
               REG_GRID_MODE:   shadow.grid_mode   = csr_pwdata[0];
               default: ;
            endcase
         end
         // results belong to older items, so retire them before taking the new one
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (awaited_cells.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result status %0d frame %0d bin %0d value %0h",
                           $realtime, rsp_status, rsp_target_frame, rsp_target_bin,
                           rsp_cell_value);
            end else begin
               want = awaited_cells.pop_front();
               if (rsp_status !== want.status || rsp_target_frame !== want.frame ||
                   rsp_target_bin !== want.bin || rsp_cell_value !== want.value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result mismatch exp %0d/%0d/%0d/%0h got %0d/%0d/%0d/%0h",
                              $realtime, want.status, want.frame, want.bin, want.value,
                              rsp_status, rsp_target_frame, rsp_target_bin,
                              rsp_cell_value);
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind_type'(req_type))
               REQ_REASSIGN: awaited_cells.push_back(reassign_bin());
               REQ_LOAD: begin
                  grid_freq[req_bin_index] = req_grid_value;
                  awaited_cells.push_back('{ST_GRID, 4'd0, req_bin_index,
                                            {9'd0, req_grid_value}});
               end
               REQ_READ: begin
                  idx = int'(req_frame) * MAX_FREQ_BINS + int'(req_bin_index);
                  awaited_cells.push_back('{ST_READ, req_frame, req_bin_index,
                                            cell_sum[idx]});
                  cell_sum[idx] = '0;
               end
               default: ;
            endcase
         end
      end
   end
endmodule

@@ dv/tb.sv @@
// Top of the spectral reassignment accumulator bench: clock, reset, register setup,
// item stimulus with random idling, watchdog and verdict. Depends on sra_pkg,
// sra_checker and the block itself.
`timescale 1ns / 1ps
module tb;
   import sra_pkg::*;

   localparam int QUIET_LIMIT = 100000;
   localparam longint ONE_Q30 = longint'(1) << 30;
   localparam int unsigned Q30_MAX = 32'h4000_0000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid, req_ready;
   logic [1:0]         req_type;
   logic [3:0]         req_frame;
   logic [9:0]         req_bin_index;
   logic [31:0]        req_power;
   logic signed [31:0] req_time_disp, req_freq_disp;
   logic [30:0]        req_grid_value;
   logic               rsp_valid, rsp_ready;
   logic [2:0]         rsp_status;
   logic [3:0]         rsp_target_frame;
   logic [9:0]         rsp_target_bin;
   logic [39:0]        rsp_cell_value;
   logic               csr_psel, csr_penable, csr_pwrite;
   logic [4:0]         csr_paddr;
   logic [31:0]        csr_pwdata, csr_prdata;
   logic               csr_pready;

   int mismatches, outstanding, results_seen;
   int items_sent, settings_run, quiet_cycles;
   bit calm;

   // stimulus-side view of the setup, used to aim displacements and pick bins
   int          cur_nb, cur_fb, cur_fs;
   bit          cur_table;
   logic [30:0] grid_copy [MAX_FREQ_BINS];

   spectral_reassignment_accumulator i_dut (.*);

   sra_checker i_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(req_kind_type kind, logic [3:0] frame, logic [9:0] bin,
                            logic [31:0] power, logic [31:0] td, logic [31:0] fd,
                            logic [30:0] gv);
      int gap;
      gap = 0;
      if (!calm) while ($urandom_range(99) < 19) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_frame      <= frame;
      req_bin_index  <= bin;
      req_power      <= power;
      req_time_disp  <= td;
      req_freq_disp  <= fd;
      req_grid_value <= gv;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // drop valid, wait for every result, then let any result-less item finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic int eff_bins(int n);
      if (n == 0) return 1;
      return (n > MAX_INPUT_BINS) ? MAX_INPUT_BINS : n;
   endfunction

   function automatic int eff_fbins();
      return (cur_fb > MAX_FREQ_BINS) ? MAX_FREQ_BINS : cur_fb;
   endfunction

   function automatic logic [31:0] rand_power();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(200);
         default: return $urandom;
      endcase
   endfunction

   // reassign aimed at a real output bin and a nearby frame, with some raw noise
   task automatic random_reassign();
      int n, nf, bin, fs;
      longint fref, target, off, td, fd;
      n  = eff_bins(cur_nb);
      nf = eff_fbins();
      fs = (cur_fs == 0) ? 1 : cur_fs;
      bin = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(n - 1);
      fref = (longint'(bin) << 30) / n;
      if (cur_table && nf > 0)
         target = longint'(grid_copy[0]) +
                  longint'($urandom_range(32'(grid_copy[nf - 1] - grid_copy[0])));
      else
         target = longint'($urandom_range(Q30_MAX));
      fd = fref - target + $signed($urandom_range(64)) - 32;
      if ($urandom_range(5) == 0) fd = $signed($urandom);
      off = $signed($urandom_range(16)) - 8;
      td  = off * fs * 4096 + $signed($urandom_range(fs * 4096)) - fs * 2048;
      if ($urandom_range(7) == 0) td = $signed($urandom);
      send_item(REQ_REASSIGN, 4'($urandom_range(15)), bin[9:0], rand_power(), td[31:0],
                fd[31:0], 31'd0);
   endtask

   task automatic random_item();
      int pick, nf;
      logic [9:0] bin;
      logic [30:0] gv;
      pick = $urandom_range(99);
      nf = eff_fbins();
      if (pick < 60) begin
         random_reassign();
      end else if (pick < 70) begin
         // keep the searched part of a loaded table intact
         if (cur_table) begin
            if (nf >= MAX_FREQ_BINS) begin
               random_reassign();
               return;
            end
            bin = 10'($urandom_range(1023, nf));
         end else begin
            bin = 10'($urandom_range(1023));
         end
         gv = 31'($urandom_range(Q30_MAX));
         if (!cur_table) grid_copy[bin] = gv;
         send_item(REQ_LOAD, 4'($urandom), bin, $urandom, $urandom, $urandom, gv);
      end else if (pick < 95) begin
         bin = ($urandom_range(4) == 0 || nf == 0) ? 10'($urandom_range(1023))
                                                   : 10'($urandom_range(nf - 1));
         send_item(REQ_READ, 4'($urandom), bin, $urandom, $urandom, $urandom,
                   31'($urandom));
      end else begin
         send_item(REQ_NONE, 4'($urandom), 10'($urandom), $urandom, $urandom, $urandom,
                   31'($urandom));
      end
   endtask

   task automatic load_table(int nf);
      longint v, step;
      v = longint'($urandom_range(1000));
      step = (ONE_Q30 / 2) / nf;
      for (int i = 0; i < nf; i++) begin
         grid_copy[i] = v[30:0];
         send_item(REQ_LOAD, 4'($urandom), i[9:0], $urandom, $urandom, $urandom, v[30:0]);
         v += 2 * longint'($urandom_range(32'(step), 1));
      end
   endtask

   task automatic apply_setting(int nb, int fb, int fs, logic [31:0] thr, int flock,
                                int lb, int la, bit table_mode, int count);
      int nf;
      longint g0, g1;
      write_reg(REG_NUM_BINS, nb);
      write_reg(REG_FREQ_BINS, fb);
      write_reg(REG_FRAME_SHIFT, fs);
      write_reg(REG_Q_THRESHOLD, thr);
      write_reg(REG_FREQ_LOCK, flock);
      write_reg(REG_LOCK_BEFORE, lb);
      write_reg(REG_LOCK_AFTER, la);
      write_reg(REG_GRID_MODE, {31'd0, table_mode});
      cur_nb = nb;
      cur_fb = fb;
      cur_fs = fs;
      cur_table = table_mode;
      settings_run++;
      if (table_mode) begin
         nf = eff_fbins();
         load_table(nf);
         // bin 0 sits at zero frequency, so x is just the negated displacement
         g0 = grid_copy[0];
         g1 = grid_copy[nf - 1];
         send_item(REQ_REASSIGN, 4'd3, 10'd0, 32'hFFFF_FFFF, 32'd0, 32'(-g0), 31'd0);
         send_item(REQ_REASSIGN, 4'd3, 10'd0, 32'hFFFF_FFFF, 32'd0, 32'(-g1), 31'd0);
         send_item(REQ_REASSIGN, 4'd3, 10'd0, 32'hFFFF_FFFF, 32'd0, 32'(-(g1 + 1)),
                   31'd0);
         if (nf >= 2) begin
            g1 = grid_copy[1];
            send_item(REQ_REASSIGN, 4'd4, 10'd0, 32'hFFFF_FFFF, 32'd0,
                      32'(-((g0 + g1) / 2)), 31'd0);
         end
      end
      repeat (count) random_item();
      drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_NONE;
      req_frame      = '0;
      req_bin_index  = '0;
      req_power      = '0;
      req_time_disp  = '0;
      req_freq_disp  = '0;
      req_grid_value = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      calm           = 1'b0;
      items_sent     = 0;
      settings_run   = 0;
      foreach (grid_copy[i]) grid_copy[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass on the default setup (shift 10, no frequency lock, time locks at zero, uniform grid)
      cur_nb = 257; cur_fb = 257; cur_fs = 10; cur_table = 0;
      send_item(REQ_READ, 4'd15, 10'd1023, 32'd0, 32'd0, 32'd0, 31'd0);
      send_item(REQ_LOAD, 4'd0, 10'd0, 32'd0, 32'd0, 32'd0, 31'd0);
      send_item(REQ_LOAD, 4'd9, 10'd1023, 32'd0, 32'd0, 32'd0, 31'h4000_0000);
      send_item(REQ_NONE, 4'd15, 10'd1023, '1, '1, '1, '1);
      send_item(REQ_REASSIGN, 4'd0, 10'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 31'd0);
      send_item(REQ_REASSIGN, 4'd0, 10'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 31'd0);
      send_item(REQ_READ, 4'd0, 10'd0, 32'd0, 32'd0, 32'd0, 31'd0);
      send_item(REQ_REASSIGN, 4'd15, 10'd256, 32'd1, 32'd20479, 32'd0, 31'd0);
      send_item(REQ_REASSIGN, 4'd15, 10'd256, 32'd1, 32'd20480, 32'd0, 31'd0);
      send_item(REQ_REASSIGN, 4'd15, 10'd256, 32'd1, -32'sd20480, 32'd0, 31'd0);
      send_item(REQ_REASSIGN, 4'd1, 10'd1023, 32'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
      send_item(REQ_REASSIGN, 4'd1, 10'd100, 32'd5, 32'd0, 32'h8000_0000, 31'd0);
      send_item(REQ_REASSIGN, 4'd2, 10'd100, 32'd0, 32'd0, 32'd0, 31'd0);
      send_item(REQ_REASSIGN, 4'd2, 10'd0, 32'd7, 32'h8000_0000, -32'sd2089, 31'd0);
      send_item(REQ_REASSIGN, 4'd2, 10'd0, 32'd7, 32'd0, -32'sd2090, 31'd0);
      send_item(REQ_READ, 4'd2, 10'd1, 32'd0, 32'd0, 32'd0, 31'd0);
      drain();

      calm = 1'b1;
      apply_setting(1024, 1024, 1, 32'd0, 0, 7, 7, 1'b0, 60);
      calm = 1'b0;
      apply_setting(0, 0, 0, 32'h8000_0000, 32'h4000_0000, 3, 2, 1'b0, 30);
      apply_setting(2047, 2047, 65535, 32'd0, 32'h0010_0000, 7, 0, 1'b0, 40);
      apply_setting(16, 8, 4, 32'd100, 0, 2, 2, 1'b1, 60);
      apply_setting(64, 1, 16, 32'd0, 0, 1, 1, 1'b1, 30);
      apply_setting(100, 40, 2, 32'd50, 32'h0100_0000, 4, 3, 1'b1, 30);
      apply_setting(8, 4, 10, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 7, 1'b0, 20);

      // pile full-scale power into one cell until it saturates, then read it back
      apply_setting(4, 4, 1, 32'd0, 0, 0, 0, 1'b0, 0);
      repeat (260) send_item(REQ_REASSIGN, 4'd5, 10'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 31'd0);
      send_item(REQ_READ, 4'd5, 10'd0, 32'd0, 32'd0, 32'd0, 31'd0);
      send_item(REQ_READ, 4'd5, 10'd0, 32'd0, 32'd0, 32'd0, 31'd0);
      drain();

      $display("Covered %0d items over %0d register setups, %0d results compared.",
               items_sent, settings_run + 1, results_seen);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatching results", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/sra_pkg.sv
rtl/sra_ram.sv
rtl/sra_div.sv
rtl/sra_csr.sv
rtl/spectral_reassignment_accumulator.sv
dv/sra_checker.sv
dv/tb.sv
